/* hdl/tmaad_pkg.sv */
package tmaad_pkg;

	localparam int unsigned SMP_W = 12;
	localparam int unsigned ARR_W = 15;
	localparam int unsigned TMR_W = 20;
	localparam int unsigned PER_W = 16;
	localparam int unsigned ANG_W = 16;
	localparam int unsigned THETA_W = 9;
	localparam int unsigned KMUL_W = 10;
	localparam int unsigned PROD_W = 27;

	localparam int unsigned RING_DEPTH_DEF = 64;
	localparam int unsigned DECIMATION_DEF = 10;

	localparam logic [SMP_W-1:0] BASE_THR_RST = 12'd1000;
	localparam logic [SMP_W-1:0] BACKOFF_RST = 12'd550;
	localparam logic [TMR_W-1:0] HOLDOFF_RST = 20'd333333;
	localparam logic [PER_W-1:0] PERIOD_RST = 16'd100;
	localparam logic [SMP_W-1:0] AVG_RST = 12'd1000;
	localparam logic [TMR_W-1:0] TIMER_MAX = 20'hFFFFF;
	localparam logic [ARR_W-1:0] ARRIVAL_MAX = 15'h7FFF;

	localparam logic [KMUL_W-1:0] K_A_FWD = 10'd512;
	localparam logic [KMUL_W-1:0] K_A_REV = 10'd384;
	localparam logic [KMUL_W-1:0] K_B = 10'd435;
	localparam logic [KMUL_W-1:0] K_C = 10'd320;
	localparam logic [THETA_W-1:0] THETA_A = 9'd120;
	localparam logic [THETA_W-1:0] THETA_B = 9'd240;
	localparam logic [THETA_W-1:0] THETA_C_FWD = 9'd0;
	localparam logic [THETA_W-1:0] THETA_C_REV = 9'd360;

	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 64;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_BASE_THR = 2'd0,
		REG_BACKOFF  = 2'd1,
		REG_HOLDOFF  = 2'd2,
		REG_PERIOD   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic fire;
		logic store;
		logic close;
		logic refresh;
	} lane_ctl_t;

	typedef struct packed {
		logic             all;
		logic [ARR_W-1:0] arr_a;
		logic [ARR_W-1:0] arr_b;
		logic [ARR_W-1:0] arr_c;
	} res_raw_t;

endpackage

/* hdl/tmaad_lane.sv */
module tmaad_lane #(
	parameter int unsigned RING_DEPTH = tmaad_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tmaad_pkg::SMP_W-1:0]    sample,
	input  logic [tmaad_pkg::SMP_W-1:0]    thr_cur,
	input  logic [tmaad_pkg::SMP_W-1:0]    thr_low,
	input  logic [tmaad_pkg::SMP_W-1:0]    old_sample,
	input  logic [tmaad_pkg::ARR_W-1:0]    timer_sat,
	input  tmaad_pkg::lane_ctl_t           ctl,
	output logic                           hit_cur,
	output logic                           hit_low,
	output logic                           fired,
	output logic                           fired_nx,
	output logic [tmaad_pkg::ARR_W-1:0]    arrival_nx
);

	localparam int unsigned LOG_D = $clog2(RING_DEPTH);
	localparam int unsigned SUM_W = tmaad_pkg::SMP_W + LOG_D;
	localparam int unsigned DIV_SHIFT = SUM_W + LOG_D;
	localparam int unsigned MULT_W = SUM_W + 1;
	localparam int unsigned PRD_W = SUM_W + MULT_W;
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);

	logic                        fired_q;
	logic [tmaad_pkg::ARR_W-1:0] arrival_q;
	logic [tmaad_pkg::SMP_W-1:0] avg_q;
	logic [SUM_W-1:0]            sum_q;
	logic [SUM_W-1:0]            sum_nx;
	logic [PRD_W-1:0]            avg_prod;
	logic [tmaad_pkg::SMP_W:0]   lim_cur;
	logic [tmaad_pkg::SMP_W:0]   lim_low;

	assign lim_cur = {1'b0, thr_cur} + {1'b0, avg_q};
	assign lim_low = {1'b0, thr_low} + {1'b0, avg_q};
	assign hit_cur = {1'b0, sample} >= lim_cur;
	assign hit_low = {1'b0, sample} >= lim_low;

	assign fired      = fired_q;
	assign fired_nx   = fired_q | ctl.fire;
	assign arrival_nx = ctl.fire ? timer_sat : arrival_q;

	assign sum_nx   = sum_q - SUM_W'(old_sample) + SUM_W'(sample);
	assign avg_prod = PRD_W'(sum_q) * PRD_W'(DIV_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q   <= 1'b0;
			arrival_q <= '0;
			avg_q     <= tmaad_pkg::AVG_RST;
			sum_q     <= '0;
		end else begin
			if (ctl.close) begin
				fired_q   <= 1'b0;
				arrival_q <= '0;
			end else if (ctl.fire) begin
				fired_q   <= 1'b1;
				arrival_q <= timer_sat;
			end
			if (ctl.store) begin
				sum_q <= sum_nx;
			end
			if (ctl.refresh) begin
				avg_q <= avg_prod[DIV_SHIFT +: tmaad_pkg::SMP_W];
			end
		end
	end

endmodule

/* hdl/tmaad_angle.sv */
module tmaad_angle (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ld,
	input  tmaad_pkg::res_raw_t                 raw,
	output logic                                room,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// all_triggered, arrival_a, arrival_b, arrival_c, angle_degrees, zero pad
	output logic [tmaad_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int unsigned SUM_W = 19;

	logic [tmaad_pkg::KMUL_W-1:0]        k_sel;
	logic [tmaad_pkg::THETA_W-1:0]       theta_sel;
	logic signed [tmaad_pkg::ANG_W-1:0]  d_sel;
	logic signed [tmaad_pkg::KMUL_W:0]   k_s;
	logic signed [tmaad_pkg::PROD_W-1:0] prod;

	logic                                v_s2_q;
	tmaad_pkg::res_raw_t                 raw_s2;
	logic [tmaad_pkg::THETA_W-1:0]       theta_s2;
	logic signed [tmaad_pkg::PROD_W-1:0] prod_s2;

	logic signed [tmaad_pkg::PROD_W-1:0] adj;
	logic signed [tmaad_pkg::PROD_W-1:0] quo;
	logic signed [SUM_W-1:0]             ang_sum;
	logic signed [tmaad_pkg::ANG_W-1:0]  ang_sat;
	logic signed [tmaad_pkg::ANG_W-1:0]  ang_fin;

	logic                                v_out_q;
	logic [tmaad_pkg::OUT_DATA_W-1:0]    data_out_q;
	logic                                s2_mv;

	always_comb begin
		k_sel     = '0;
		theta_sel = '0;
		d_sel     = '0;
		if (raw.arr_a == '0) begin
			theta_sel = tmaad_pkg::THETA_A;
			if (raw.arr_b >= raw.arr_c) begin
				k_sel = tmaad_pkg::K_A_FWD;
				d_sel = $signed({1'b0, raw.arr_c}) - $signed({1'b0, raw.arr_b});
			end else begin
				k_sel = tmaad_pkg::K_A_REV;
				d_sel = $signed({1'b0, raw.arr_b}) - $signed({1'b0, raw.arr_c});
			end
		end else if (raw.arr_b == '0) begin
			theta_sel = tmaad_pkg::THETA_B;
			k_sel     = tmaad_pkg::K_B;
			if (raw.arr_c >= raw.arr_a) begin
				d_sel = $signed({1'b0, raw.arr_a}) - $signed({1'b0, raw.arr_c});
			end else begin
				d_sel = $signed({1'b0, raw.arr_c}) - $signed({1'b0, raw.arr_a});
			end
		end else if (raw.arr_c == '0) begin
			k_sel = tmaad_pkg::K_C;
			d_sel = $signed({1'b0, raw.arr_b}) - $signed({1'b0, raw.arr_a});
			theta_sel = (raw.arr_b >= raw.arr_a) ? tmaad_pkg::THETA_C_FWD :
				tmaad_pkg::THETA_C_REV;
		end
	end

	assign k_s  = $signed({1'b0, k_sel});
	assign prod = k_s * d_sel;

	assign room  = !v_s2_q || !v_out_q || m_tready;
	assign s2_mv = v_s2_q && (!v_out_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (ld) begin
			v_s2_q <= 1'b1;
		end else if (s2_mv) begin
			v_s2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			raw_s2   <= raw;
			theta_s2 <= theta_sel;
			prod_s2  <= prod;
		end
	end

	always_comb begin
		adj     = prod_s2 + (prod_s2[tmaad_pkg::PROD_W-1] ? 27'sd255 : 27'sd0);
		quo     = adj >>> 8;
		ang_sum = $signed(quo[SUM_W-1:0]) +
			$signed({{(SUM_W-tmaad_pkg::THETA_W){1'b0}}, theta_s2});
		if (ang_sum > 19'sd32767) begin
			ang_sat = 16'sh7FFF;
		end else if (ang_sum < -19'sd32768) begin
			ang_sat = 16'sh8000;
		end else begin
			ang_sat = ang_sum[tmaad_pkg::ANG_W-1:0];
		end
		ang_fin = raw_s2.all ? ang_sat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (s2_mv) begin
			v_out_q <= 1'b1;
		end else if (m_tready) begin
			v_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_mv) begin
			data_out_q <= {2'b00, ang_fin, raw_s2.arr_c, raw_s2.arr_b, raw_s2.arr_a,
				raw_s2.all};
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = data_out_q;

endmodule

/* hdl/three_mic_arrival_angle_detector.sv */
// channel   | dir | handshake                        | payload
// s_*       | in  | s_tvalid / s_tready              | s_tdata: sample_a, sample_b, sample_c
// m_*       | out | m_tvalid / m_tready              | m_tdata: all_triggered, arrivals, angle
// apb       | in  | psel & penable & pwrite & pready | pwdata at paddr 4*index
//
// One sample set per cycle while s_tready is high; the window logic and the three trigger
// decisions are combinational. A sample set whose period count ends with no open window is
// followed by a refresh that stalls the input: averages are reloaded from the ring sums
// by the reciprocal multiplier. A result is registered in raw_s1, raw_s2, then data_out_q.
// Reset clears all control state; ring memory entries read as zero until first written.
// Apart from the refresh cycle, the input stalls only while three results wait on a
// stalled output.
module three_mic_arrival_angle_detector #(
	parameter int unsigned RING_DEPTH = tmaad_pkg::RING_DEPTH_DEF,
	parameter int unsigned DECIMATION = tmaad_pkg::DECIMATION_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample_a [11:0], sample_b [23:12], sample_c [35:24], zero pad
	input  logic [tmaad_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// all_triggered [0], arrival_a [15:1], arrival_b [30:16], arrival_c [45:31],
	// angle_degrees [61:46], zero pad
	output logic [tmaad_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tmaad_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tmaad_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tmaad_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam int unsigned SW = tmaad_pkg::SMP_W;
	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned DEC_W = $clog2(DECIMATION + 1);
	localparam int unsigned ROW_W = 3 * SW;

	logic [SW-1:0]                 base_q;
	logic [SW-1:0]                 backoff_q;
	logic [tmaad_pkg::TMR_W-1:0]   holdoff_q;
	logic [tmaad_pkg::PER_W-1:0]   period_q;

	logic                          open_q;
	logic [SW-1:0]                 wt_q;
	logic [tmaad_pkg::TMR_W-1:0]   timer_q;
	logic [PTR_W-1:0]              ptr_q;
	logic [PTR_W-1:0]              ptr_nx;
	logic                          full_q;
	logic [DEC_W-1:0]              dec_q;
	logic [tmaad_pkg::PER_W-1:0]   per_q;
	logic                          pending_q;

	logic [ROW_W-1:0]              ring_mem [RING_DEPTH];
	logic [ROW_W-1:0]              ring_rd_q;

	logic                          v_s1_q;
	tmaad_pkg::res_raw_t           raw_s1;
	tmaad_pkg::res_raw_t           raw_nx;

	logic                          accept;
	logic                          cfg_we;
	tmaad_pkg::reg_idx_t           cfg_idx;
	logic [SW-1:0]                 lowered;
	logic [tmaad_pkg::ARR_W-1:0]   timer_sat;
	logic [SW-1:0]                 samp     [3];
	logic [SW-1:0]                 old_samp [3];
	logic [2:0]                    hit_cur;
	logic [2:0]                    hit_low;
	logic [2:0]                    fired;
	logic [2:0]                    fired_nx;
	logic [tmaad_pkg::ARR_W-1:0]   arr_nx   [3];
	logic [2:0]                    fire;
	logic                          opened;
	logic                          open_mid;
	logic                          close;
	logic                          store;
	logic [tmaad_pkg::PER_W:0]     per_inc;
	logic                          per_hit;
	logic                          room;
	logic                          s1_ld;
	tmaad_pkg::lane_ctl_t          ctl      [3];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !pending_q && (!v_s1_q || room);
	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite;
	assign cfg_idx  = tmaad_pkg::reg_idx_t'(paddr[3:2]);

	assign lowered   = (base_q > backoff_q) ? (base_q - backoff_q) : '0;
	assign timer_sat = (|timer_q[tmaad_pkg::TMR_W-1:tmaad_pkg::ARR_W]) ?
		tmaad_pkg::ARRIVAL_MAX : timer_q[tmaad_pkg::ARR_W-1:0];

	assign store  = accept && (dec_q == '0);
	assign ptr_nx = !store ? ptr_q :
		(ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	// a window opened by an earlier microphone lowers the threshold for the later ones
	always_comb begin
		fire[0]  = accept && !fired[0] && hit_cur[0];
		fire[1]  = accept && !fired[1] &&
			((!open_q && fire[0]) ? hit_low[1] : hit_cur[1]);
		fire[2]  = accept && !fired[2] &&
			((!open_q && (fire[0] || fire[1])) ? hit_low[2] : hit_cur[2]);
		opened   = !open_q && (|fire);
		open_mid = open_q || (|fire);
		close    = accept && open_mid && (timer_q >= holdoff_q);
	end

	assign per_inc = {1'b0, per_q} + 1'b1;
	assign per_hit = per_inc >= {1'b0, period_q};

	generate
		for (genvar i = 0; i < 3; i++) begin : g_lane
			assign samp[i]     = s_tdata[i*SW +: SW];
			assign old_samp[i] = full_q ? ring_rd_q[i*SW +: SW] : '0;
			assign ctl[i]      = '{fire: fire[i], store: store, close: close,
				refresh: pending_q};

			tmaad_lane #(
				.RING_DEPTH (RING_DEPTH)
			) u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.sample     (samp[i]),
				.thr_cur    (wt_q),
				.thr_low    (lowered),
				.old_sample (old_samp[i]),
				.timer_sat  (timer_sat),
				.ctl        (ctl[i]),
				.hit_cur    (hit_cur[i]),
				.hit_low    (hit_low[i]),
				.fired      (fired[i]),
				.fired_nx   (fired_nx[i]),
				.arrival_nx (arr_nx[i])
			);
		end
	endgenerate

	assign raw_nx = '{all: &fired_nx, arr_a: arr_nx[0], arr_b: arr_nx[1], arr_c: arr_nx[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= tmaad_pkg::BASE_THR_RST;
			backoff_q <= tmaad_pkg::BACKOFF_RST;
			holdoff_q <= tmaad_pkg::HOLDOFF_RST;
			period_q  <= tmaad_pkg::PERIOD_RST;
			open_q    <= 1'b0;
			wt_q      <= tmaad_pkg::BASE_THR_RST;
			timer_q   <= '0;
			ptr_q     <= '0;
			full_q    <= 1'b0;
			dec_q     <= '0;
			per_q     <= '0;
			pending_q <= 1'b0;
		end else begin
			pending_q <= accept && per_hit && !(open_mid && !close);
			if (accept) begin
				open_q <= open_mid && !close;
				if (close) begin
					wt_q    <= base_q;
					timer_q <= '0;
				end else begin
					if (opened) begin
						wt_q <= lowered;
					end
					if (open_mid && (timer_q != tmaad_pkg::TIMER_MAX)) begin
						timer_q <= timer_q + 1'b1;
					end
				end
				ptr_q <= ptr_nx;
				if (store && (ptr_q == PTR_W'(RING_DEPTH - 1))) begin
					full_q <= 1'b1;
				end
				dec_q <= (dec_q == DEC_W'(DECIMATION - 1)) ? '0 : dec_q + 1'b1;
				per_q <= per_hit ? '0 : per_inc[tmaad_pkg::PER_W-1:0];
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					tmaad_pkg::REG_BASE_THR: begin
						base_q <= pwdata[SW-1:0];
						if (!open_q) begin
							wt_q <= pwdata[SW-1:0];
						end
					end
					tmaad_pkg::REG_BACKOFF: begin
						backoff_q <= pwdata[SW-1:0];
					end
					tmaad_pkg::REG_HOLDOFF: begin
						holdoff_q <= pwdata[tmaad_pkg::TMR_W-1:0];
					end
					tmaad_pkg::REG_PERIOD: begin
						period_q <= pwdata[tmaad_pkg::PER_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (cfg_idx)
			tmaad_pkg::REG_BASE_THR: prdata = tmaad_pkg::APB_DATA_W'(base_q);
			tmaad_pkg::REG_BACKOFF:  prdata = tmaad_pkg::APB_DATA_W'(backoff_q);
			tmaad_pkg::REG_HOLDOFF:  prdata = tmaad_pkg::APB_DATA_W'(holdoff_q);
			tmaad_pkg::REG_PERIOD:   prdata = tmaad_pkg::APB_DATA_W'(period_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store) begin
			ring_mem[ptr_q] <= s_tdata[ROW_W-1:0];
		end
		ring_rd_q <= ring_mem[ptr_nx];
	end

	assign s1_ld = v_s1_q && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (close) begin
			v_s1_q <= 1'b1;
		end else if (s1_ld) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			raw_s1 <= raw_nx;
		end
	end

	tmaad_angle u_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (s1_ld),
		.raw      (raw_s1),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/tmaad_check.sv */
module tmaad_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tmaad_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [tmaad_pkg::APB_ADDR_W-1:0]    paddr,
	input logic [tmaad_pkg::APB_DATA_W-1:0]    pwdata,
	input logic [tmaad_pkg::APB_DATA_W-1:0]    prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result request changed");

	a_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[61:46] == '0)
		else $error("angle nonzero without all triggers");

	a_first_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
			(m_tdata[15:1] == '0) || (m_tdata[30:16] == '0) || (m_tdata[45:31] == '0))
		else $error("complete event without a zero arrival");

	a_backoff_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == {tmaad_pkg::REG_BACKOFF, 2'b00}) ##1
			(paddr == {tmaad_pkg::REG_BACKOFF, 2'b00}) |->
			prdata[11:0] == $past(pwdata[11:0]))
		else $error("backoff register readback mismatch");

endmodule

bind three_mic_arrival_angle_detector tmaad_check u_check (.*);
